@@ hw/rtl/checked_byte_buffer_access_assert.svh @@
// ----------------------------------------------------------------------------
// checked_byte_buffer_access assertion macros
// concurrent assertion shorthands clocked on clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef CHECKED_BYTE_BUFFER_ACCESS_ASSERT_SVH
`define CHECKED_BYTE_BUFFER_ACCESS_ASSERT_SVH

// implication or plain property checked at every clock edge out of reset
`define CBBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression that must never be true out of reset
`define CBBA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/cbba_pkg.sv @@
// ----------------------------------------------------------------------------
// cbba_pkg
// shared constants, codes and types of the checked byte buffer access block
// ----------------------------------------------------------------------------
package cbba_pkg;

	// buffer capacity in bytes, a power of two and at least four
	localparam int BUF_BYTES = 4096;
	localparam int ROWS      = BUF_BYTES / 4;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int LEN_W     = 13;

	localparam logic [31:0] BUF_BYTES_W = 32'(BUF_BYTES);

	// commands
	localparam logic [2:0] CMD_RD_BYTE = 3'd0;
	localparam logic [2:0] CMD_WR_BYTE = 3'd1;
	localparam logic [2:0] CMD_RD_HALF = 3'd2;
	localparam logic [2:0] CMD_WR_HALF = 3'd3;
	localparam logic [2:0] CMD_RD_WORD = 3'd4;
	localparam logic [2:0] CMD_WR_WORD = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BOUNDS = 2'd1;
	localparam logic [1:0] ST_ALIGN  = 2'd2;
	localparam logic [1:0] ST_VALUE  = 2'd3;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_BYTE,
		RK_HALF,
		RK_WORD
	} rd_kind_t;

	// what the result stage needs to build one result word
	typedef struct packed {
		logic [1:0] status;
		rd_kind_t   rd_kind;
		logic       big;
		logic [1:0] lane;
	} fmt_t;

	// decoded and checked access
	typedef struct packed {
		fmt_t             fmt;
		logic [ROW_W-1:0] row;
		logic [3:0]       wr_en;
		logic [31:0]      wr_data;
	} check_t;

endpackage

@@ hw/rtl/cbba_check.sv @@
// ----------------------------------------------------------------------------
// cbba_check
// decodes one access, checks sign, alignment, bounds and byte value, and
// places write bytes on their lanes
// ----------------------------------------------------------------------------
module cbba_check import cbba_pkg::*; (
	input  logic [2:0]       command,
	input  logic             big_endian,
	input  logic [31:0]      offset,
	input  logic [31:0]      write_value,
	input  logic [LEN_W-1:0] buffer_length,
	output check_t           chk
);

	logic [31:0] len_ext;
	logic [31:0] lim;
	logic [32:0] end_sum;
	logic        is_half;
	logic        misaligned;
	logic [15:0] pair;
	logic [31:0] word_swap;

	assign len_ext = 32'(buffer_length);
	assign lim     = (len_ext > BUF_BYTES_W) ? BUF_BYTES_W : len_ext;

	assign is_half    = (command == CMD_RD_HALF) || (command == CMD_WR_HALF);
	assign misaligned = is_half ? offset[0] : (|offset[1:0]);
	assign end_sum    = {1'b0, offset} + (is_half ? 33'd2 : 33'd4);

	assign pair      = big_endian ? {write_value[7:0], write_value[15:8]} : write_value[15:0];
	assign word_swap = {write_value[7:0], write_value[15:8], write_value[23:16],
		write_value[31:24]};

	always_comb begin
		chk.fmt.status  = ST_OK;
		chk.fmt.rd_kind = RK_NONE;
		chk.fmt.big     = big_endian;
		chk.fmt.lane    = offset[1:0];
		chk.row         = offset[ROW_W+1:2];
		chk.wr_en       = 4'b0000;
		chk.wr_data     = '0;
		case (command)
			CMD_RD_BYTE, CMD_WR_BYTE: begin
				if (offset >= lim) begin
					chk.fmt.status = ST_BOUNDS;
				end else if (command == CMD_RD_BYTE) begin
					chk.fmt.rd_kind = RK_BYTE;
				end else if (|write_value[31:8]) begin
					chk.fmt.status = ST_VALUE;
				end else begin
					chk.wr_en   = 4'b0001 << offset[1:0];
					chk.wr_data = {4{write_value[7:0]}};
				end
			end
			CMD_RD_HALF, CMD_WR_HALF, CMD_RD_WORD, CMD_WR_WORD: begin
				if (offset[31] || misaligned) begin
					chk.fmt.status = ST_ALIGN;
				end else if (end_sum > {1'b0, lim}) begin
					chk.fmt.status = ST_BOUNDS;
				end else if (is_half) begin
					if (command == CMD_RD_HALF) begin
						chk.fmt.rd_kind = RK_HALF;
					end else begin
						chk.wr_en   = offset[1] ? 4'b1100 : 4'b0011;
						chk.wr_data = {2{pair}};
					end
				end else begin
					if (command == CMD_RD_WORD) begin
						chk.fmt.rd_kind = RK_WORD;
					end else begin
						chk.wr_en   = 4'b1111;
						chk.wr_data = big_endian ? word_swap : write_value;
					end
				end
			end
			default: begin
				// unused commands do nothing
				chk.fmt.status = ST_OK;
			end
		endcase
	end

endmodule

@@ hw/rtl/cbba_store.sv @@
// ----------------------------------------------------------------------------
// cbba_store
// byte buffer as rows of four byte lanes with per-lane write enables, a
// registered row read and a zeroing sweep after reset
// ----------------------------------------------------------------------------
module cbba_store import cbba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] row,
	input  logic [3:0]       wr_en,
	input  logic [31:0]      wr_data,
	input  logic             rd_en,
	output logic [31:0]      rd_data,
	output logic             clear_done
);

	logic [31:0]    mem [ROWS];
	logic [ROW_W:0] clr_q;

	// top bit of the sweep counter marks the end of the sweep
	assign clear_done = clr_q[ROW_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[ROW_W]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[ROW_W]) begin
			mem[clr_q[ROW_W-1:0]] <= '0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (wr_en[i]) begin
					mem[row][i*8 +: 8] <= wr_data[i*8 +: 8];
				end
			end
		end
		if (rd_en) begin
			rd_data <= mem[row];
		end
	end

endmodule

@@ hw/rtl/cbba_format.sv @@
// ----------------------------------------------------------------------------
// cbba_format
// picks the bytes of a read out of the row and orders them by endianness
// ----------------------------------------------------------------------------
module cbba_format import cbba_pkg::*; (
	input  fmt_t        fmt,
	input  logic [31:0] row_data,
	output logic [31:0] data
);

	logic [15:0] pair;

	assign pair = fmt.lane[1] ? row_data[31:16] : row_data[15:0];

	always_comb begin
		case (fmt.rd_kind)
			RK_BYTE: begin
				data = {24'b0, row_data[{fmt.lane, 3'b000} +: 8]};
			end
			RK_HALF: begin
				data = fmt.big ? {16'b0, pair[7:0], pair[15:8]} : {16'b0, pair};
			end
			RK_WORD: begin
				data = fmt.big ? {row_data[7:0], row_data[15:8], row_data[23:16],
					row_data[31:24]} : row_data;
			end
			default: begin
				data = '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/checked_byte_buffer_access.sv @@
// ----------------------------------------------------------------------------
// checked_byte_buffer_access
// bounds-checked byte buffer load/store unit
// ----------------------------------------------------------------------------
// Command channel: command, big_endian, offset, write_value with cmd_valid,
// taken at a clock edge where cmd_valid is high and cmd_stall is low.
// Response channel: read_data and status with rsp_valid, taken when
// rsp_stall is low. One response per command, in order.
// The user must write buffer_length through cfg_wr_en / cfg_wr_data only
// while idle; the block does not enforce it. Timing: checks and the write
// happen in the accept cycle, the row read is registered there, and the
// result register follows it. One command per cycle is taken while
// cmd_stall is low; a write is seen by a read accepted in the next cycle.
// Reset: buffer_length clears, and a zeroing sweep writes one row of four
// bytes per cycle with cmd_stall held high.
// Receiver stall: the response register holds, the middle stage still
// takes one more command, then cmd_stall rises until the response moves.
// ----------------------------------------------------------------------------
module checked_byte_buffer_access import cbba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic [2:0]       command,
	input  logic             big_endian,
	input  logic [31:0]      offset,
	input  logic [31:0]      write_value,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [31:0]      read_data,
	output logic [1:0]       status
);

	logic [LEN_W-1:0] buffer_length_q;
	check_t           chk;
	logic             clear_done;
	logic             accept;
	logic             s2_load;
	logic             s1_free;
	logic             s1_valid_q;
	fmt_t             fmt_s1;
	logic [31:0]      row_s1;
	logic [31:0]      data_fmt;
	logic             rsp_valid_q;
	logic [31:0]      read_data_s2;
	logic [1:0]       status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (cfg_wr_en) begin
			buffer_length_q <= cfg_wr_data;
		end
	end

	cbba_check u_check (
		.command       (command),
		.big_endian    (big_endian),
		.offset        (offset),
		.write_value   (write_value),
		.buffer_length (buffer_length_q),
		.chk           (chk)
	);

	assign s2_load   = !rsp_valid_q || !rsp_stall;
	assign s1_free   = !s1_valid_q || s2_load;
	assign cmd_stall = !clear_done || !s1_free;
	assign accept    = cmd_valid && !cmd_stall;

	cbba_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.row        (chk.row),
		.wr_en      (accept ? chk.wr_en : 4'b0000),
		.wr_data    (chk.wr_data),
		.rd_en      (accept && (chk.fmt.rd_kind != RK_NONE)),
		.rd_data    (row_s1),
		.clear_done (clear_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_free) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_s1 <= chk.fmt;
		end
	end

	cbba_format u_format (
		.fmt      (fmt_s1),
		.row_data (row_s1),
		.data     (data_fmt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s2_load) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && s1_valid_q) begin
			read_data_s2 <= data_fmt;
			status_s2    <= fmt_s1.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_s2;
	assign status    = status_s2;

`include "checked_byte_buffer_access_assert.svh"

	`CBBA_NEVER(a_no_accept_in_sweep, accept && !clear_done, "command taken during zeroing sweep")
	`CBBA_NEVER(a_trap_no_write, (|chk.wr_en) && (chk.fmt.status != ST_OK), "trapped access writes")
	`CBBA_ASSERT(a_s1_holds, (s1_valid_q && !s2_load) |=> s1_valid_q, "middle stage lost a word")
	`CBBA_ASSERT(a_trap_zero, (rsp_valid && (status != ST_OK)) |-> (read_data == '0), "trap data nonzero")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for checked_byte_buffer_access: a table of directed
// accesses, then random phases at several buffer lengths, each response is
// held to a fixed result or a local byte mirror, both sides idling at random
// ----------------------------------------------------------------------------
module testbench;
	import cbba_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int N_DIRECTED    = 27;
	localparam int N_PHASES      = 10;
	localparam int PHASE_ACCESSES = 125;
	localparam int DRAIN_CYCLES  = 10;

	// command codes the block leaves unused
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  status;
	} access_result_t;

	typedef enum logic {
		STEP_ACCESS,
		STEP_SET_LENGTH
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [2:0]  cmd;
		logic        big;
		logic [31:0] off;
		logic [31:0] val;
		logic        fixed;
		logic [31:0] fixed_data;
		logic [1:0]  fixed_status;
	} directed_step_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;
	logic             cmd_valid;
	logic             cmd_stall;
	logic [2:0]       command;
	logic             big_endian;
	logic [31:0]      offset;
	logic [31:0]      write_value;
	logic             rsp_valid;
	logic             rsp_stall;
	logic [31:0]      read_data;
	logic [1:0]       status;

	// mirror of the block's buffer and its length register
	logic [7:0]       mirror_bytes [BUF_BYTES];
	logic [LEN_W-1:0] mirror_length;

	access_result_t awaited_results [$];
	int errors;
	int accesses_sent;
	int results_checked;
	int lengths_set;
	int cycle_count;
	int burst_left;

	logic [LEN_W-1:0] phase_lengths [7] = '{13'd16, 13'd8191, 13'd1, 13'd4096, 13'd0,
		13'd4097, 13'd6};

	// kind, cmd, big, offset, value, fixed?, data, status
	directed_step_t directed_steps [N_DIRECTED] = '{
		'{STEP_ACCESS, CMD_RD_BYTE, 1'b0, 32'h0, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b0, 32'h0, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_RD_HALF, 1'b0, 32'hFFFF_FFFE, 32'h0, 1'b1, 32'h0, ST_ALIGN},
		'{STEP_ACCESS, CMD_SPARE_6, 1'b1, 32'h0, 32'h1, 1'b1, 32'h0, ST_OK},
		'{STEP_SET_LENGTH, CMD_RD_BYTE, 1'b0, 32'h0, 32'd8191, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b0, 32'd4092, 32'h0, 1'b1, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_WR_WORD, 1'b0, 32'd4092, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b1, 32'd4092, 32'h0, 1'b1, 32'hFFFF_FFFF, ST_OK},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b0, 32'd4096, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b0, 32'h7FFF_FFFC, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_RD_BYTE, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_WR_BYTE, 1'b0, 32'd4096, 32'd300, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_WR_BYTE, 1'b0, 32'h0, 32'd256, 1'b1, 32'h0, ST_VALUE},
		'{STEP_ACCESS, CMD_WR_BYTE, 1'b0, 32'h1, 32'd255, 1'b1, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_WR_HALF, 1'b0, 32'h1, 32'h1234, 1'b1, 32'h0, ST_ALIGN},
		'{STEP_ACCESS, CMD_WR_WORD, 1'b1, 32'h2, 32'h1234, 1'b1, 32'h0, ST_ALIGN},
		'{STEP_ACCESS, CMD_WR_WORD, 1'b0, 32'h0, 32'h1234_5678, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b1, 32'h0, 32'h0, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_HALF, 1'b1, 32'h2, 32'h0, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_HALF, 1'b0, 32'h0, 32'h0, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_WR_HALF, 1'b1, 32'd4094, 32'hABCD_EF01, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_BYTE, 1'b0, 32'd4095, 32'h0, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_HALF, 1'b0, 32'h8000_0000, 32'h0, 1'b1, 32'h0, ST_ALIGN},
		'{STEP_ACCESS, CMD_SPARE_7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK},
		'{STEP_SET_LENGTH, CMD_RD_BYTE, 1'b0, 32'h0, 32'd6, 1'b0, 32'h0, ST_OK},
		'{STEP_ACCESS, CMD_RD_WORD, 1'b0, 32'h4, 32'h0, 1'b1, 32'h0, ST_BOUNDS},
		'{STEP_ACCESS, CMD_RD_HALF, 1'b0, 32'h4, 32'h0, 1'b0, 32'h0, ST_OK}
	};

	checked_byte_buffer_access dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.big_endian  (big_endian),
		.offset      (offset),
		.write_value (write_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.read_data   (read_data),
		.status      (status)
	);

	always #6 clk = ~clk;

	// one access against the mirror; updates it on a good write
	function automatic access_result_t buffer_access(input logic [2:0] cmd, input logic big,
		input logic [31:0] off, input logic [31:0] val);
		access_result_t r;
		logic [31:0] usable;
		int size;
		int pos;
		r.data = '0;
		r.status = ST_OK;
		usable = (32'(mirror_length) < BUF_BYTES_W) ? 32'(mirror_length) : BUF_BYTES_W;
		if (cmd == CMD_RD_BYTE || cmd == CMD_WR_BYTE) begin
			if (off >= usable) begin
				r.status = ST_BOUNDS;
			end else if (cmd == CMD_RD_BYTE) begin
				r.data[7:0] = mirror_bytes[off];
			end else if (val > 32'd255) begin
				r.status = ST_VALUE;
			end else begin
				mirror_bytes[off] = val[7:0];
			end
		end else if (cmd == CMD_RD_HALF || cmd == CMD_WR_HALF || cmd == CMD_RD_WORD ||
			cmd == CMD_WR_WORD) begin
			size = (cmd == CMD_RD_HALF || cmd == CMD_WR_HALF) ? 2 : 4;
			if (off[31] || (off & 32'(size - 1)) != 0) begin
				r.status = ST_ALIGN;
			end else if (33'(off) + 33'(size) > 33'(usable)) begin
				r.status = ST_BOUNDS;
			end else begin
				for (int i = 0; i < size; i++) begin
					pos = big ? size - 1 - i : i;
					if (cmd == CMD_WR_HALF || cmd == CMD_WR_WORD)
						mirror_bytes[off + pos] = val[8*i +: 8];
					else
						r.data[8*i +: 8] = mirror_bytes[off + pos];
				end
			end
		end
		return r;
	endfunction

	// present one word and hold it until taken
	task automatic issue_access(input logic [2:0] cmd, input logic big, input logic [31:0] off,
		input logic [31:0] val, input logic fixed, input access_result_t fixed_result);
		access_result_t predicted;
		cmd_valid <= 1'b1;
		command <= cmd;
		big_endian <= big;
		offset <= off;
		write_value <= val;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		predicted = buffer_access(cmd, big, off, val);
		awaited_results.push_back(fixed ? fixed_result : predicted);
		accesses_sent++;
	endtask

	task automatic sender_gap();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if (roll < 3) begin
			burst_left = $urandom_range(20, 60);
			gap = 0;
		end else if (roll < 60) begin
			gap = 0;
		end else if (roll < 92) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// length is only written with nothing in flight
	task automatic set_length(input logic [LEN_W-1:0] len);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mirror_length = len;
		lengths_set++;
	endtask

	task automatic random_access();
		logic [2:0]  cmd;
		logic        big;
		logic [31:0] off;
		logic [31:0] val;
		logic [31:0] usable;
		logic [31:0] window;
		logic [31:0] base;
		int size;
		int shape;
		if ($urandom_range(0, 99) < 4)
			cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
		else
			cmd = 3'($urandom_range(0, 5));
		size = (cmd <= CMD_WR_BYTE) ? 1 : (cmd <= CMD_WR_HALF) ? 2 : 4;
		usable = (32'(mirror_length) < BUF_BYTES_W) ? 32'(mirror_length) : BUF_BYTES_W;
		// keep most traffic in a small window so reads land on earlier writes
		window = (usable > 32'd256 && $urandom_range(0, 9) != 0) ? 32'd256 : usable;
		shape = $urandom_range(0, 99);
		if (shape < 70 && window >= 32'(size)) begin
			off = 32'($urandom_range(0, window / size - 1)) * size;
		end else if (shape < 82) begin
			base = usable & ~32'(size - 1);
			off = base + 32'(size * $urandom_range(0, 2)) - 32'(size);
		end else if (shape < 92) begin
			off = 32'($urandom_range(0, window + 3));
		end else begin
			off = $urandom();
		end
		if (cmd == CMD_WR_BYTE && $urandom_range(0, 99) < 80)
			val = 32'($urandom_range(0, 255));
		else
			val = $urandom();
		big = 1'($urandom_range(0, 1));
		issue_access(cmd, big, off, val, 1'b0, '0);
	endtask

	// random stall pattern on the response side
	initial begin : stall_pattern
		int run;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			rsp_stall <= 1'b0;
			repeat (run) @(posedge clk);
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
			if (run > 0) begin
				rsp_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : response_check
		access_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected word: read_data %h status %0d", read_data, status);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				if (read_data !== want.data) begin
					$error("read_data: expected %h, got %h", want.data, read_data);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		access_result_t fixed_result;
		logic [LEN_W-1:0] len;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cmd_valid = 1'b0;
		command = CMD_RD_BYTE;
		big_endian = 1'b0;
		offset = '0;
		write_value = '0;
		rsp_stall = 1'b0;
		errors = 0;
		accesses_sent = 0;
		results_checked = 0;
		lengths_set = 0;
		cycle_count = 0;
		burst_left = 0;
		mirror_length = '0;
		for (int i = 0; i < BUF_BYTES; i++)
			mirror_bytes[i] = 8'h00;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_steps[i].kind == STEP_SET_LENGTH) begin
				set_length(LEN_W'(directed_steps[i].val));
			end else begin
				fixed_result.data = directed_steps[i].fixed_data;
				fixed_result.status = directed_steps[i].fixed_status;
				issue_access(directed_steps[i].cmd, directed_steps[i].big,
					directed_steps[i].off, directed_steps[i].val,
					directed_steps[i].fixed, fixed_result);
				sender_gap();
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			len = (p < 7) ? phase_lengths[p] : LEN_W'($urandom_range(2, 8191));
			set_length(len);
			for (int n = 0; n < PHASE_ACCESSES; n++) begin
				random_access();
				sender_gap();
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("testbench: %0d accesses issued, %0d responses checked, %0d length writes",
			accesses_sent, results_checked, lengths_set);
		$display("testbench: lengths from 0 to 8191, byte/half/word in both byte orders");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
